/* rtl/core/vlmr_pkg.sv */
// Package: ring constants, channel payload types, controller/datapath interface types.
`timescale 1ns / 1ps
package vlmr_pkg;

	localparam int RING_WORDS    = 1024;
	localparam int MAX_MSG_WORDS = 32;
	localparam int IDX_W         = $clog2(RING_WORDS);
	localparam int CNT_W         = $clog2(MAX_MSG_WORDS + 1);

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_PUSH_OK   = 2'd0,
		ST_PUSH_DROP = 2'd1,
		ST_POP_WORD  = 2'd2,
		ST_EMPTY     = 2'd3
	} res_status_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] data_word;
		logic        last_word;
		logic [7:0]  byte_length;
	} item_t;

	typedef struct packed {
		res_status_t status;
		logic [31:0] data_word_res;
		logic [7:0]  byte_length_res;
		logic        last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic push;       // accept a push transaction
		logic pop_empty;  // accept a pop on an empty ring
		logic pop_start;  // accept a pop, read header word
		logic pop_hdr;    // header in, read next-index word
		logic pop_nxt;    // next index in, read first payload word
		logic pop_word;   // payload word out
		logic wr_hdr;     // commit: write length header
		logic wr_nxt;     // commit: write next index, move write pointer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_pop;
		logic is_last;
		logic commit_ok;
		logic empty;
		logic n_zero;
		logic stream_last;
	} sts_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == IDX_W'(RING_WORDS - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

/* rtl/core/vlmr_ctrl.sv */
// Controller: sequences push commits and pop streaming.
`timescale 1ns / 1ps
module vlmr_ctrl import vlmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_WR_HDR   = 6'b000010,
		S_WR_NXT   = 6'b000100,
		S_POP_HDR  = 6'b001000,
		S_POP_NXT  = 6'b010000,
		S_POP_WORD = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!sts.is_pop) begin
						cmd.push = 1'b1;
						if (sts.is_last && sts.commit_ok) state_d = S_WR_HDR;
					end else if (sts.empty) begin
						cmd.pop_empty = 1'b1;
					end else begin
						cmd.pop_start = 1'b1;
						state_d = S_POP_HDR;
					end
				end
			end
			S_WR_HDR: begin
				cmd.wr_hdr = 1'b1;
				state_d = S_WR_NXT;
			end
			S_WR_NXT: begin
				cmd.wr_nxt = 1'b1;
				state_d = S_IDLE;
			end
			S_POP_HDR: begin
				cmd.pop_hdr = 1'b1;
				state_d = S_POP_NXT;
			end
			S_POP_NXT: begin
				cmd.pop_nxt = 1'b1;
				state_d = sts.n_zero ? S_IDLE : S_POP_WORD;
			end
			S_POP_WORD: begin
				cmd.pop_word = 1'b1;
				if (sts.stream_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/core/vlmr_datapath.sv */
// Datapath: ring memory, ring pointers, open-message tracking and result register.
`timescale 1ns / 1ps
module vlmr_datapath import vlmr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t result,
	output logic    result_valid
);

	logic [31:0] mem [RING_WORDS];
	logic [31:0] rdata_q;

	logic [IDX_W-1:0] rd_idx_q, wr_idx_q, pend_idx_q;
	logic [CNT_W-1:0] pend_words_q;
	logic             pend_drop_q;

	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q, cnt_q;
	logic [7:0]       len_q, hdr_len_q;
	result_t          result_q;
	result_t          result_d;
	logic             result_valid_q;

	// push evaluation
	logic             first, drop0, drop1, store, len_match, commit_ok;
	logic [IDX_W-1:0] second, p_idx0, p_idx1;
	logic [CNT_W-1:0] words1;
	logic [8:0]       need_sum;

	// pop header decode
	logic [8:0]       hdr_sum;
	logic [CNT_W-1:0] hdr_n;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [31:0]      wdata;
	res_status_t      push_status;

	always_comb begin
		first  = (pend_words_q == '0) && !pend_drop_q;
		second = ring_next(wr_idx_q);
		p_idx0 = first ? ring_next(second) : pend_idx_q;
		// header slots of a new message must not reach the oldest message
		drop0  = pend_drop_q ||
		         (first && (second == rd_idx_q) && (rd_idx_q != wr_idx_q));
		drop1  = drop0;
		store  = 1'b0;
		p_idx1 = p_idx0;
		words1 = pend_words_q;
		if (!drop0) begin
			if ((pend_words_q >= CNT_W'(MAX_MSG_WORDS)) || (p_idx0 == rd_idx_q)) begin
				drop1 = 1'b1;
			end else begin
				store  = 1'b1;
				p_idx1 = ring_next(p_idx0);
				words1 = pend_words_q + 1'b1;
			end
		end
		need_sum  = 9'(item.byte_length) + 9'd3;
		len_match = (9'(words1) == {2'b00, need_sum[8:2]});
		commit_ok = !drop1 && (item.byte_length != 8'd0) && len_match &&
		            (p_idx1 != rd_idx_q);
		if (item.last_word) push_status = commit_ok ? ST_PUSH_OK : ST_PUSH_DROP;
		else push_status = drop1 ? ST_PUSH_DROP : ST_PUSH_OK;
	end

	always_comb begin
		hdr_sum = 9'(rdata_q[7:0]) + 9'd3;
		if (hdr_sum[8:2] > 7'(MAX_MSG_WORDS)) hdr_n = CNT_W'(MAX_MSG_WORDS);
		else hdr_n = CNT_W'(hdr_sum[8:2]);
	end

	always_comb begin
		we    = 1'b0;
		waddr = p_idx0;
		wdata = item.data_word;
		if (cmd.push && store) begin
			we = 1'b1;
		end else if (cmd.wr_hdr) begin
			we    = 1'b1;
			waddr = wr_idx_q;
			wdata = {24'd0, hdr_len_q};
		end else if (cmd.wr_nxt) begin
			we    = 1'b1;
			waddr = ring_next(wr_idx_q);
			wdata = 32'(pend_idx_q);
		end
		raddr = cmd.pop_start ? rd_idx_q : ring_next(idx_q);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign sts.is_pop      = (item.action == ACT_POP);
	assign sts.is_last     = item.last_word;
	assign sts.commit_ok   = commit_ok;
	assign sts.empty       = (rd_idx_q == wr_idx_q);
	assign sts.n_zero      = (n_q == '0);
	assign sts.stream_last = (cnt_q == n_q - 1'b1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q       <= '0;
			wr_idx_q       <= '0;
			pend_idx_q     <= '0;
			pend_words_q   <= '0;
			pend_drop_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.push || cmd.pop_empty || cmd.pop_word ||
			                  (cmd.pop_nxt && (n_q == '0));
			if (cmd.push) begin
				pend_idx_q <= p_idx1;
				if (item.last_word) begin
					pend_words_q <= '0;
					pend_drop_q  <= 1'b0;
				end else begin
					pend_words_q <= words1;
					pend_drop_q  <= drop1;
				end
			end
			if (cmd.wr_nxt) wr_idx_q <= pend_idx_q;
			// stored next index is always below the ring size
			if (cmd.pop_nxt) rd_idx_q <= rdata_q[IDX_W-1:0];
		end
	end

	always_comb begin
		result_d      = '0;
		result_d.last = 1'b1;
		if (cmd.push) begin
			result_d.status = push_status;
		end else if (cmd.pop_word) begin
			result_d.status          = ST_POP_WORD;
			result_d.data_word_res   = rdata_q;
			result_d.byte_length_res = len_q;
			result_d.last            = (cnt_q == n_q - 1'b1);
		end else begin
			result_d.status = ST_EMPTY;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.push) hdr_len_q <= item.byte_length;
		if (cmd.pop_start) idx_q <= rd_idx_q;
		else if (cmd.pop_hdr || cmd.pop_nxt || cmd.pop_word) idx_q <= ring_next(idx_q);
		if (cmd.pop_hdr) begin
			len_q <= rdata_q[7:0];
			n_q   <= hdr_n;
		end
		if (cmd.pop_nxt) cnt_q <= '0;
		else if (cmd.pop_word) cnt_q <= cnt_q + 1'b1;

		result_q <= result_d;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* rtl/core/variable_length_message_ring.sv */
// Top level: variable-length message ring, controller plus datapath.
//
//  channel  | signals                      | handshake
//  ---------+------------------------------+-----------------------------------------
//  input    | start, busy, item (item_t)   | taken at clk edge with start & !busy
//  result   | result_valid, result         | one-cycle strobe, no backpressure
//
//  A push word that does not commit a message leaves the block idle, so the next item
//  may follow at once. A push that commits then writes the length header and next index,
//  busy meanwhile, as payload, header and next index each need the single write port.
//  A pop streams n payload words: the accept cycle issues the header read, header and
//  next-index decode follow, then one word per cycle from the registered read port. An
//  empty pop stays idle. Results are registered and appear in the cycle after the work
//  that makes them. arst_n clears pointers and control; the ring needs no clear.
`timescale 1ns / 1ps
module variable_length_message_ring import vlmr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	cmd_t cmd;
	sts_t sts;

	vlmr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	vlmr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
